>>> design/fpl_pkg.sv
// Shared types and constants for the free page list allocator.
`default_nettype none

package fpl_pkg;

  localparam int PAGE_W   = 10;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_CAP   = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EXTEND,
    S_EXT_READ
  } fsm_state_t;

  typedef struct packed {
    logic    capture;
    logic    pop;
    logic    push;
    logic    err;
    status_t err_code;
    logic    ext_step;
    logic    ext_read;
  } fpl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic head_zero;
    logic cap_ok;
    logic free_ok;
    logic ext_last;
    logic out_busy;
  } fpl_sts_t;

endpackage

`default_nettype wire

>>> design/fpl_ctrl.sv
// Sequencing state machine for the free page list allocator.
`default_nettype none

module fpl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpl_pkg::fpl_sts_t  sts,
  output fpl_pkg::fpl_cmd_t  cmd
);
  import fpl_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.err_code = ST_OK;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result slot can take a transaction
        if (!sts.out_busy) begin
          state_next = S_IDLE;
          if (sts.is_free) begin
            if (sts.free_ok) begin
              cmd.push = 1'b1;
            end else begin
              cmd.err      = 1'b1;
              cmd.err_code = ST_BAD_FREE;
            end
          end else if (!sts.head_zero) begin
            cmd.pop = 1'b1;
          end else if (sts.cap_ok) begin
            state_next = S_EXTEND;
          end else begin
            cmd.err      = 1'b1;
            cmd.err_code = ST_NO_CAP;
          end
        end
      end
      S_EXTEND: begin
        cmd.ext_step = 1'b1;
        if (sts.ext_last) begin
          state_next = S_EXT_READ;
        end
      end
      S_EXT_READ: begin
        cmd.ext_read = 1'b1;
        state_next   = S_EXEC;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/fpl_dp.sv
// Link memory, list head, page count and result register of the allocator.
`default_nettype none

module fpl_dp #(
  parameter int MAX_PAGES     = 1024,
  parameter int RESERVE_PAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          operation,
  input  logic [fpl_pkg::PAGE_W-1:0]    page_number,
  input  logic                          out_ready,
  input  fpl_pkg::fpl_cmd_t             cmd,
  output fpl_pkg::fpl_sts_t             sts,
  output logic                          out_valid,
  output logic [fpl_pkg::PAGE_W-1:0]    page_number_res,
  output fpl_pkg::status_t              status
);
  import fpl_pkg::*;

  localparam int PW   = $clog2(MAX_PAGES);
  localparam int CW   = $clog2(MAX_PAGES + 1);
  localparam int SW   = $clog2(MAX_PAGES + RESERVE_PAGES + 1);
  localparam int RW   = (RESERVE_PAGES > 1) ? $clog2(RESERVE_PAGES) : 1;
  localparam int CMPW = (CW > PAGE_W) ? CW : PAGE_W;

  logic [PW-1:0]     mem [MAX_PAGES];
  logic [PW-1:0]     rdata;
  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic [PW-1:0]     mem_wdata;
  logic              mem_re;

  op_t               op_q;
  logic [PAGE_W-1:0] pg_q;
  logic [PW-1:0]     head;
  logic [CW-1:0]     page_count;
  logic [RW-1:0]     cnt;
  logic [SW-1:0]     ext_page;
  logic [SW-1:0]     count_plus_run;

  assign ext_page       = SW'(page_count) + SW'(cnt);
  assign count_plus_run = SW'(page_count) + SW'(RESERVE_PAGES);

  assign sts.is_free   = (op_q == OP_FREE);
  assign sts.head_zero = (head == '0);
  assign sts.cap_ok    = (count_plus_run <= SW'(MAX_PAGES));
  assign sts.free_ok   = (pg_q != '0) && (CMPW'(pg_q) < CMPW'(page_count));
  assign sts.ext_last  = (cnt == RW'(RESERVE_PAGES - 1));
  assign sts.out_busy  = out_valid && !out_ready;

  // one write port: either a run link or a pushed page
  always_comb begin
    mem_we    = cmd.ext_step || cmd.push;
    mem_waddr = PW'(ext_page);
    mem_wdata = sts.ext_last ? '0 : PW'(ext_page + SW'(1));
    if (cmd.push) begin
      mem_waddr = PW'(pg_q);
      mem_wdata = head;
    end
  end

  // read the head's link ahead of a pop
  assign mem_re = cmd.capture || cmd.ext_read;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op_t'(operation);
      pg_q <= page_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      page_count <= CW'(1);
      cnt        <= '0;
    end else begin
      if (cmd.ext_step) begin
        if (sts.ext_last) begin
          cnt        <= '0;
          head       <= PW'(page_count);
          page_count <= CW'(count_plus_run);
        end else begin
          cnt <= cnt + RW'(1);
        end
      end
      if (cmd.pop) begin
        head <= rdata;
      end
      if (cmd.push) begin
        head <= PW'(pg_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop || cmd.push || cmd.err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      page_number_res <= PAGE_W'(head);
      status          <= ST_OK;
    end else if (cmd.push) begin
      page_number_res <= '0;
      status          <= ST_OK;
    end else if (cmd.err) begin
      page_number_res <= '0;
      status          <= cmd.err_code;
    end
  end

endmodule

`default_nettype wire

>>> design/free_page_list_allocator.sv
// Top level of the free page list allocator: controller plus datapath.
`default_nettype none

// Hands out page numbers from a singly linked free list and takes them back.
// Page 0 is the header and the end-of-list mark. Each transaction carries an
// operation (allocate or free) and a page number; each produces exactly one
// result transaction with the allocated page (0 on free or error) and a
// status (ok, no capacity, invalid page freed). An allocate with an empty
// list first links RESERVE_PAGES fresh pages numbered from the page count,
// then pops; if the run would pass MAX_PAGES it fails and nothing changes.
// Freeing page 0 or a page at or above the page count fails likewise. Double
// frees are not detected. Timing: one transaction is in flight at a time; a
// plain allocate pops the head using its link, read synchronously from the
// link memory (one read port, one write port). An allocate that extends the
// list first links its fresh run, one link written per cycle, then reads the
// new head's link. A waiting result does not block acceptance of the next
// transaction until that one needs the result register. Links are undefined
// after reset and need no clearing pass, as a link is used only once written.
module free_page_list_allocator #(
  parameter int MAX_PAGES     = 1024,
  parameter int RESERVE_PAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic [fpl_pkg::PAGE_W-1:0]        page_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fpl_pkg::PAGE_W-1:0]        page_number_res,
  output logic [fpl_pkg::STATUS_W-1:0]      status
);
  import fpl_pkg::*;

  fpl_cmd_t cmd;
  fpl_sts_t sts;
  status_t  status_q;

  fpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpl_dp #(
    .MAX_PAGES     (MAX_PAGES),
    .RESERVE_PAGES (RESERVE_PAGES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .operation       (operation),
    .page_number     (page_number),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .page_number_res (page_number_res),
    .status          (status_q)
  );

  assign status = status_q;

  // One transaction at a time: acceptance drops ready for the work.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // Failed transactions never hand out a page.
  a_err_page_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q != ST_OK) |-> (page_number_res == '0))
    else $error("error result carries a page number");

  // A finished extension leaves a non-empty list.
  a_ext_fills_list: assert property (@(posedge clk) disable iff (rst)
    (cmd.ext_step && sts.ext_last) |=> !sts.head_zero)
    else $error("list still empty after linking a fresh run");

  // A result only appears from a completed operation.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.pop || cmd.push || cmd.err))
    else $error("result raised without a completed operation");

endmodule

`default_nettype wire
